FILE: design/tsbm_pkg.sv
// ----------------------------------------------------------------------------
// tsbm_pkg
// Types, constants and CRC-32/MPEG-2 helpers for the TS block marker generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tsbm_pkg;

  localparam logic [7:0]  TS_SYNC        = 8'h47;
  localparam logic [12:0] NULL_PID       = 13'h1FFF;
  localparam logic [7:0]  SECT_TABLE_ID  = 8'hBF;
  localparam logic [7:0]  SECT_LENGTH    = 8'h14;
  localparam logic [31:0] CRC_POLY       = 32'h04C11DB7;
  localparam logic [31:0] CRC_INIT       = 32'hFFFFFFFF;
  localparam logic [7:0]  RTP_CNT_MAX    = 8'hFF;
  localparam logic [7:0]  RTP_PER_MARKER_RST = 8'd5;

  // Section is 23 bytes; 128 of its bits come from marker fields
  localparam int SECT_BITS = 184;
  localparam int VAR_BITS  = 128;

  // Fixed header bytes of the section, all variable fields zero
  localparam logic [SECT_BITS-1:0] SECT_FIXED =
    {SECT_TABLE_ID, 8'h00, SECT_LENGTH, 160'h0};

  // Marker fields as carried through the pipeline
  typedef struct packed {
    logic        forward_packet;
    logic        marker_valid;
    logic [31:0] marker_number;
    logic [15:0] marker_non_null;
    logic [15:0] marker_null;
    logic [15:0] marker_start_seq;
    logic [15:0] marker_next_seq;
    logic [31:0] marker_ssrc;
  } marker_t;

  // Place the variable fields {number, data count, null count, start, next,
  // ssrc} at their section positions; fixed bytes stay zero
  function automatic logic [SECT_BITS-1:0] sect_place(input logic [VAR_BITS-1:0] v);
    return {24'h0, v[127:64], 16'h0, v[63:48], 16'h0, v[47:0]};
  endfunction

  // Bit-serial CRC-32/MPEG-2, MSB first; used at elaboration only
  function automatic logic [31:0] crc_msg(input logic [SECT_BITS-1:0] msg,
                                          input logic [31:0] init);
    logic [31:0] c;
    logic        fb;
    c = init;
    for (int i = SECT_BITS - 1; i >= 0; i--) begin
      fb = c[31] ^ msg[i];
      c  = {c[30:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // Contribution of each variable bit to the CRC (zero initial value)
  function automatic logic [VAR_BITS-1:0][31:0] crc_columns();
    logic [VAR_BITS-1:0][31:0] cols;
    for (int i = 0; i < VAR_BITS; i++) begin
      cols[i] = crc_msg(sect_place(VAR_BITS'(1) << i), 32'h0);
    end
    return cols;
  endfunction

  localparam logic [VAR_BITS-1:0][31:0] CRC_COLS = crc_columns();
  localparam logic [31:0] CRC_BASE = crc_msg(SECT_FIXED, CRC_INIT);

endpackage

`default_nettype wire

FILE: design/tsbm_if.sv
// ----------------------------------------------------------------------------
// tsbm interfaces
// Valid/ready channels of the TS block marker generator: packet header input,
// marker result output and configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsbm_in_if;
  logic        valid;
  logic        ready;
  logic        ts_present;
  logic [7:0]  ts_sync_byte;
  logic [12:0] ts_pid;
  logic        first_in_rtp;
  logic        last_in_rtp;
  logic [15:0] rtp_seq;
  logic [31:0] stream_ssrc;

  modport source (output valid, ts_present, ts_sync_byte, ts_pid, first_in_rtp,
                  last_in_rtp, rtp_seq, stream_ssrc, input ready);
  modport sink   (input valid, ts_present, ts_sync_byte, ts_pid, first_in_rtp,
                  last_in_rtp, rtp_seq, stream_ssrc, output ready);
endinterface

interface tsbm_out_if;
  logic        valid;
  logic        ready;
  logic        forward_packet;
  logic        marker_valid;
  logic [31:0] marker_number;
  logic [15:0] marker_non_null;
  logic [15:0] marker_null;
  logic [15:0] marker_start_seq;
  logic [15:0] marker_next_seq;
  logic [31:0] marker_ssrc;
  logic [31:0] marker_crc;

  modport source (output valid, forward_packet, marker_valid, marker_number,
                  marker_non_null, marker_null, marker_start_seq, marker_next_seq,
                  marker_ssrc, marker_crc, input ready);
  modport sink   (input valid, forward_packet, marker_valid, marker_number,
                  marker_non_null, marker_null, marker_start_seq, marker_next_seq,
                  marker_ssrc, marker_crc, output ready);
endinterface

interface tsbm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] rtp_per_marker;

  modport source (output valid, rtp_per_marker, input ready);
  modport sink   (input valid, rtp_per_marker, output ready);
endinterface

`default_nettype wire

FILE: design/ts_block_marker_generator.sv
// ----------------------------------------------------------------------------
// ts_block_marker_generator
// Counts TS packets per block of RTP packets and emits marker fields with
// the CRC-32/MPEG-2 of the marker's private section.
// ----------------------------------------------------------------------------
// Usage:
//   ts_in  : one TS packet header per beat, tagged with RTP sequence and SSRC.
//   mk_out : exactly one result beat per input beat, in order. forward_packet
//            tells whether the TS packet passes; marker_* fields are nonzero
//            only on the beat after which a marker packet is inserted.
//   cfg    : write of rtp_per_marker, always ready; write only while idle.
// Two registers lie between input beat and result beat: the first register
// holds the updated counts and marker fields, the second holds them with
// the CRC, which is one XOR tree over the 128 variable section bits.
// Throughput is one beat per cycle when mk_out is ready.
// When mk_out stalls, both pipeline registers fill and ts_in.ready drops;
// nothing is lost or repeated, and the pipeline refills at full rate.
// Reset clears the counters, sets the marker number to 1 and
// rtp_per_marker to 5, and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module ts_block_marker_generator (
  input  wire logic   clk,
  input  wire logic   rst,
  tsbm_in_if.sink     ts_in,
  tsbm_out_if.source  mk_out,
  tsbm_cfg_if.sink    cfg
);

  // Configuration and block state
  logic [7:0]  rtp_per_marker;
  logic [31:0] marker_count;
  logic [7:0]  rtp_in_block;
  logic [15:0] block_start_seq;
  logic [15:0] block_next_seq;
  logic [15:0] data_pkt_count;
  logic [15:0] null_pkt_count;

  logic [31:0] marker_count_next;
  logic [7:0]  rtp_in_block_next;
  logic [15:0] block_start_seq_next;
  logic [15:0] block_next_seq_next;
  logic [15:0] data_pkt_count_next;
  logic [15:0] null_pkt_count_next;

  // Pipeline registers
  logic                 s1_valid;
  tsbm_pkg::marker_t    s1;
  tsbm_pkg::marker_t    s1_next;
  logic                 out_valid;
  tsbm_pkg::marker_t    out_reg;
  logic [31:0]          out_crc;

  logic        in_accept;
  logic        out_load;
  logic        s1_free;
  logic        fwd;
  logic        fire;
  logic [7:0]  rtp_inc;
  logic [15:0] start_sel;
  logic [15:0] nn_upd;
  logic [15:0] nl_upd;
  logic [15:0] seq_plus;
  logic [tsbm_pkg::VAR_BITS-1:0] crc_bits;
  logic [31:0] crc_val;

  // Handshake
  assign out_load    = s1_valid && (!out_valid || mk_out.ready);
  assign s1_free     = !s1_valid || out_load;
  assign ts_in.ready = s1_free;
  assign in_accept   = ts_in.valid && s1_free;
  assign cfg.ready   = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      rtp_per_marker <= tsbm_pkg::RTP_PER_MARKER_RST;
    end else if (cfg.valid) begin
      rtp_per_marker <= cfg.rtp_per_marker;
    end
  end

  // Next block state and marker fields for the beat on ts_in
  always_comb begin
    fwd       = ts_in.ts_present && (ts_in.ts_sync_byte == tsbm_pkg::TS_SYNC);
    start_sel = (ts_in.first_in_rtp && (rtp_in_block == 8'd0)) ? ts_in.rtp_seq
                                                                : block_start_seq;
    nn_upd    = data_pkt_count;
    nl_upd    = null_pkt_count;
    if (fwd) begin
      if (ts_in.ts_pid == tsbm_pkg::NULL_PID) begin
        nl_upd = null_pkt_count + 16'd1;
      end else begin
        nn_upd = data_pkt_count + 16'd1;
      end
    end
    rtp_inc  = (rtp_in_block == tsbm_pkg::RTP_CNT_MAX) ? rtp_in_block
                                                        : rtp_in_block + 8'd1;
    seq_plus = ts_in.rtp_seq + 16'd1;
    fire     = ts_in.last_in_rtp && (rtp_inc >= rtp_per_marker);

    marker_count_next    = marker_count;
    rtp_in_block_next    = rtp_in_block;
    block_start_seq_next = start_sel;
    block_next_seq_next  = block_next_seq;
    data_pkt_count_next  = nn_upd;
    null_pkt_count_next  = nl_upd;

    s1_next                = '0;
    s1_next.forward_packet = fwd;

    if (ts_in.last_in_rtp) begin
      rtp_in_block_next   = rtp_inc;
      block_next_seq_next = seq_plus;
      if (fire) begin
        s1_next.marker_valid     = 1'b1;
        s1_next.marker_number    = marker_count;
        s1_next.marker_non_null  = nn_upd;
        s1_next.marker_null      = nl_upd;
        s1_next.marker_start_seq = start_sel;
        s1_next.marker_next_seq  = seq_plus;
        s1_next.marker_ssrc      = ts_in.stream_ssrc;
        marker_count_next        = marker_count + 32'd1;
        rtp_in_block_next        = 8'd0;
        data_pkt_count_next      = 16'd0;
        null_pkt_count_next      = 16'd0;
        block_start_seq_next     = seq_plus;
      end
    end
  end

  // Advance block state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      marker_count    <= 32'd1;
      rtp_in_block    <= 8'd0;
      block_start_seq <= 16'd0;
      block_next_seq  <= 16'd0;
      data_pkt_count  <= 16'd0;
      null_pkt_count  <= 16'd0;
    end else if (in_accept) begin
      marker_count    <= marker_count_next;
      rtp_in_block    <= rtp_in_block_next;
      block_start_seq <= block_start_seq_next;
      block_next_seq  <= block_next_seq_next;
      data_pkt_count  <= data_pkt_count_next;
      null_pkt_count  <= null_pkt_count_next;
    end
  end

  // First pipeline register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= ts_in.valid;
    end
  end

  // First pipeline register: payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1 <= s1_next;
    end
  end

  // CRC as a constant plus one column per set variable bit
  always_comb begin
    crc_bits = {s1.marker_number, s1.marker_non_null, s1.marker_null,
                s1.marker_start_seq, s1.marker_next_seq, s1.marker_ssrc};
    crc_val  = tsbm_pkg::CRC_BASE;
    for (int i = 0; i < tsbm_pkg::VAR_BITS; i++) begin
      if (crc_bits[i]) begin
        crc_val = crc_val ^ tsbm_pkg::CRC_COLS[i];
      end
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (mk_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_reg <= s1;
      out_crc <= s1.marker_valid ? crc_val : 32'd0;
    end
  end

  assign mk_out.valid            = out_valid;
  assign mk_out.forward_packet   = out_reg.forward_packet;
  assign mk_out.marker_valid     = out_reg.marker_valid;
  assign mk_out.marker_number    = out_reg.marker_number;
  assign mk_out.marker_non_null  = out_reg.marker_non_null;
  assign mk_out.marker_null      = out_reg.marker_null;
  assign mk_out.marker_start_seq = out_reg.marker_start_seq;
  assign mk_out.marker_next_seq  = out_reg.marker_next_seq;
  assign mk_out.marker_ssrc      = out_reg.marker_ssrc;
  assign mk_out.marker_crc       = out_crc;

  // Reset leaves the block at its start values
  a_reset_state: assert property (@(posedge clk)
    rst |=> (marker_count == 32'd1) && (rtp_in_block == 8'd0) && !s1_valid && !out_valid)
    else $error("block state not cleared by reset");

  // A marker advances the marker number by one and restarts the block
  a_marker_restart: assert property (@(posedge clk) disable iff (rst)
    (in_accept && fire) |=>
      (marker_count == $past(marker_count) + 32'd1) && (rtp_in_block == 8'd0)
      && (data_pkt_count == 16'd0) && (null_pkt_count == 16'd0))
    else $error("marker did not restart the block");

  // A held first-stage beat is never dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_load) |=> s1_valid && $stable(s1))
    else $error("first-stage beat lost while stalled");

  // Without a marker, the CRC, marker number and SSRC of a result are zero
  a_no_marker_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_reg.marker_valid) |->
      (out_crc == 32'd0) && (out_reg.marker_number == 32'd0)
      && (out_reg.marker_ssrc == 32'd0))
    else $error("marker fields set without a marker");

  // Only the end of an RTP packet moves the RTP count
  a_marker_no_empty_pass: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !ts_in.last_in_rtp) |=> (rtp_in_block == $past(rtp_in_block)))
    else $error("RTP count changed without an RTP packet end");

endmodule

`default_nettype wire

FILE: test/tb_ts_block_marker_generator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ts_block_marker_generator
// Self-checking bench for the TS block marker generator. A short stimulus
// table covers field extremes, bad sync, missing first flags and register
// changes in the middle of a block. Random RTP packets follow, with sender
// and receiver stalls, then at full rate.
// Every result beat is checked field by field against the table or a bench-side model.
// ----------------------------------------------------------------------------

module tb_ts_block_marker_generator;

  localparam int LIMIT_CYCLES = 1_000_000;

  typedef struct packed {
    logic        ts_present;
    logic [7:0]  ts_sync_byte;
    logic [12:0] ts_pid;
    logic        first_in_rtp;
    logic        last_in_rtp;
    logic [15:0] rtp_seq;
    logic [31:0] stream_ssrc;
  } ts_hdr_t;

  typedef struct packed {
    logic        fwd;
    logic        mk_valid;
    logic [31:0] number;
    logic [15:0] data_pkts;
    logic [15:0] null_pkts;
    logic [15:0] start_seq;
    logic [15:0] next_seq;
    logic [31:0] ssrc;
    logic [31:0] crc;
  } marker_res_t;

  // One row of the directed table: a register write or a header beat
  typedef struct packed {
    logic       is_cfg;
    logic [7:0] cfg_val;
    logic       typed;
    logic       typed_fwd;
    ts_hdr_t    hdr;
  } dir_row_t;

  logic clk;
  logic rst;

  tsbm_in_if  ts_in();
  tsbm_out_if mk_out();
  tsbm_cfg_if cfg();

  ts_block_marker_generator DUT (
    .clk    (clk),
    .rst    (rst),
    .ts_in  (ts_in),
    .mk_out (mk_out),
    .cfg    (cfg)
  );

  // Bench-side copy of the block state
  logic [7:0]  per_marker_reg;
  logic [31:0] marker_num;
  logic [7:0]  rtps_in_block;
  logic [15:0] blk_start_seq;
  logic [15:0] blk_next_seq;
  logic [15:0] data_pkt_cnt;
  logic [15:0] null_cnt;

  marker_res_t pending_results[$];
  dir_row_t    dir_rows[$];

  int          send_idle_pct;
  int          recv_idle_pct;
  int          fail_count;
  int          beat_count;
  int          cycle_count;
  logic [15:0] rtp_seq_ctr;
  logic [31:0] stream_id;

  // Toggle the clock
  always #1 clk = ~clk;

  // CRC-32/MPEG-2 over the 23-byte private section, MSB first, no final XOR
  function automatic logic [31:0] section_crc(input logic [31:0] num,
                                              input logic [15:0] nn,
                                              input logic [15:0] nl,
                                              input logic [15:0] st,
                                              input logic [15:0] nx,
                                              input logic [31:0] ssrc);
    logic [183:0] sect;
    logic [31:0]  c;
    sect = {tsbm_pkg::SECT_TABLE_ID, 8'h00, tsbm_pkg::SECT_LENGTH, num, nn, nl,
            16'h0000, st, 16'h0000, nx, ssrc};
    c = tsbm_pkg::CRC_INIT;
    for (int i = 22; i >= 0; i--) begin
      c = c ^ {sect[i*8 +: 8], 24'h000000};
      for (int k = 0; k < 8; k++) begin
        c = c[31] ? ((c << 1) ^ tsbm_pkg::CRC_POLY) : (c << 1);
      end
    end
    return c;
  endfunction

  // Advance the model by one header beat and return its result
  function automatic marker_res_t predict_marker(input ts_hdr_t h);
    marker_res_t r;
    logic        fwd;
    r   = '0;
    fwd = h.ts_present && (h.ts_sync_byte == tsbm_pkg::TS_SYNC);
    // block start first, then the TS count, then the RTP packet end
    if (h.first_in_rtp && rtps_in_block == 8'd0) begin
      blk_start_seq = h.rtp_seq;
    end
    if (fwd) begin
      if (h.ts_pid == tsbm_pkg::NULL_PID) begin
        null_cnt = null_cnt + 16'd1;
      end else begin
        data_pkt_cnt = data_pkt_cnt + 16'd1;
      end
    end
    r.fwd = fwd;
    if (h.last_in_rtp) begin
      if (rtps_in_block != tsbm_pkg::RTP_CNT_MAX) begin
        rtps_in_block = rtps_in_block + 8'd1;
      end
      blk_next_seq = h.rtp_seq + 16'd1;
      if (rtps_in_block >= per_marker_reg) begin
        r.mk_valid  = 1'b1;
        r.number    = marker_num;
        r.data_pkts = data_pkt_cnt;
        r.null_pkts = null_cnt;
        r.start_seq = blk_start_seq;
        r.next_seq  = blk_next_seq;
        r.ssrc      = h.stream_ssrc;
        r.crc       = section_crc(marker_num, data_pkt_cnt, null_cnt, blk_start_seq,
                                  blk_next_seq, h.stream_ssrc);
        marker_num    = marker_num + 32'd1;
        rtps_in_block = 8'd0;
        data_pkt_cnt  = 16'd0;
        null_cnt      = 16'd0;
        blk_start_seq = blk_next_seq;
      end
    end
    return r;
  endfunction

  function automatic dir_row_t row_item(input logic present, input logic [7:0] sync,
                                        input logic [12:0] pid, input logic first,
                                        input logic last, input logic [15:0] seq,
                                        input logic [31:0] ssrc, input logic typed,
                                        input logic typed_fwd);
    dir_row_t row;
    row                   = '0;
    row.typed             = typed;
    row.typed_fwd         = typed_fwd;
    row.hdr.ts_present    = present;
    row.hdr.ts_sync_byte  = sync;
    row.hdr.ts_pid        = pid;
    row.hdr.first_in_rtp  = first;
    row.hdr.last_in_rtp   = last;
    row.hdr.rtp_seq       = seq;
    row.hdr.stream_ssrc   = ssrc;
    return row;
  endfunction

  function automatic dir_row_t row_cfg(input logic [7:0] val);
    dir_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.cfg_val = val;
    return row;
  endfunction

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    $display("[%0t] beat %0d: %s got 0x%08h want 0x%08h", $time, beat_count, what,
             got, want);
  endtask

  task automatic match_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  // Drive one header beat, hold it until accepted, then log its result
  task automatic send_hdr(input ts_hdr_t h, input logic typed, input logic typed_fwd);
    marker_res_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      ts_in.valid = 1'b0;
      @(negedge clk);
    end
    ts_in.valid        = 1'b1;
    ts_in.ts_present   = h.ts_present;
    ts_in.ts_sync_byte = h.ts_sync_byte;
    ts_in.ts_pid       = h.ts_pid;
    ts_in.first_in_rtp = h.first_in_rtp;
    ts_in.last_in_rtp  = h.last_in_rtp;
    ts_in.rtp_seq      = h.rtp_seq;
    ts_in.stream_ssrc  = h.stream_ssrc;
    do @(posedge clk); while (ts_in.ready !== 1'b1);
    r = predict_marker(h);
    if (typed) begin
      r     = '0;
      r.fwd = typed_fwd;
    end
    pending_results.push_back(r);
  endtask

  // Drop valid and wait until every result is back and the pipeline is empty
  task automatic drain_results();
    @(negedge clk);
    ts_in.valid = 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_rtp_per_marker(input logic [7:0] val);
    drain_results();
    @(negedge clk);
    cfg.valid          = 1'b1;
    cfg.rtp_per_marker = val;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    per_marker_reg = val;
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // Send one RTP packet of random TS headers; some packets carry broken flags
  task automatic send_rtp_packet(output int n_items);
    int      len;
    logic    broken;
    ts_hdr_t h;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
    if ($urandom_range(0, 19) == 0) begin
      stream_id = $urandom;
    end
    rtp_seq_ctr = ($urandom_range(0, 19) == 0) ? 16'($urandom) : rtp_seq_ctr + 16'd1;
    broken = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < len; i++) begin
      h.ts_present   = ($urandom_range(0, 9) != 0);
      h.ts_sync_byte = ($urandom_range(0, 9) != 0) ? tsbm_pkg::TS_SYNC : 8'($urandom);
      h.ts_pid       = ($urandom_range(0, 2) == 0) ? tsbm_pkg::NULL_PID : 13'($urandom);
      h.first_in_rtp = (i == 0);
      h.last_in_rtp  = (i == len - 1);
      h.rtp_seq      = rtp_seq_ctr;
      h.stream_ssrc  = stream_id;
      if (broken) begin
        h.first_in_rtp = 1'($urandom_range(0, 1));
        h.last_in_rtp  = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1) == 1) begin
          h.rtp_seq     = 16'($urandom);
          h.stream_ssrc = $urandom;
        end
      end
      send_hdr(h, 1'b0, 1'b0);
    end
    n_items = len;
  endtask

  task automatic run_random(input int n_target);
    int sent;
    int n;
    sent = 0;
    while (sent < n_target) begin
      send_rtp_packet(n);
      sent += n;
    end
  endtask

  // Stall the result side at random
  always @(negedge clk) begin
    mk_out.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    marker_res_t want;
    if (!rst && mk_out.valid === 1'b1 && mk_out.ready === 1'b1) begin
      beat_count++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'd0, 32'd0);
      end else begin
        want = pending_results.pop_front();
        match_field("forward_packet", 32'(mk_out.forward_packet), 32'(want.fwd));
        match_field("marker_valid", 32'(mk_out.marker_valid), 32'(want.mk_valid));
        match_field("marker_number", mk_out.marker_number, want.number);
        match_field("marker_non_null", 32'(mk_out.marker_non_null),
                    32'(want.data_pkts));
        match_field("marker_null", 32'(mk_out.marker_null), 32'(want.null_pkts));
        match_field("marker_start_seq", 32'(mk_out.marker_start_seq),
                    32'(want.start_seq));
        match_field("marker_next_seq", 32'(mk_out.marker_next_seq),
                    32'(want.next_seq));
        match_field("marker_ssrc", mk_out.marker_ssrc, want.ssrc);
        match_field("marker_crc", mk_out.marker_crc, want.crc);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    clk                = 1'b0;
    rst                = 1'b1;
    ts_in.valid        = 1'b0;
    ts_in.ts_present   = 1'b0;
    ts_in.ts_sync_byte = 8'h00;
    ts_in.ts_pid       = 13'h0000;
    ts_in.first_in_rtp = 1'b0;
    ts_in.last_in_rtp  = 1'b0;
    ts_in.rtp_seq      = 16'h0000;
    ts_in.stream_ssrc  = 32'h0;
    cfg.valid          = 1'b0;
    cfg.rtp_per_marker = 8'h00;
    mk_out.ready       = 1'b0;
    fail_count         = 0;
    beat_count         = 0;
    cycle_count        = 0;
    send_idle_pct      = 29;
    recv_idle_pct      = 84;
    rtp_seq_ctr        = 16'h0100;
    stream_id          = 32'h1357_9BDF;

    // model state after reset
    per_marker_reg = tsbm_pkg::RTP_PER_MARKER_RST;
    marker_num     = 32'd1;
    rtps_in_block  = 8'd0;
    blk_start_seq  = 16'd0;
    blk_next_seq   = 16'd0;
    data_pkt_cnt   = 16'd0;
    null_cnt       = 16'd0;

    // Directed table: no-marker rows carry their result, the rest use the model
    dir_rows.push_back(row_item(1'b0, 8'h00, 13'h0000, 1'b0, 1'b0, 16'h0000,
                                32'h0000_0000, 1'b1, 1'b0));
    dir_rows.push_back(row_item(1'b1, 8'h46, 13'h0000, 1'b0, 1'b0, 16'h0000,
                                32'h0000_0000, 1'b1, 1'b0));
    dir_rows.push_back(row_item(1'b1, 8'h48, tsbm_pkg::NULL_PID, 1'b0, 1'b0, 16'h0000,
                                32'h0000_0000, 1'b1, 1'b0));
    dir_rows.push_back(row_item(1'b1, tsbm_pkg::TS_SYNC, tsbm_pkg::NULL_PID, 1'b1, 1'b1,
                                16'hFFFF, 32'h0000_0000, 1'b1, 1'b1));
    dir_rows.push_back(row_item(1'b1, tsbm_pkg::TS_SYNC, 13'h0000, 1'b1, 1'b0, 16'h0001,
                                32'h0000_0000, 1'b1, 1'b1));
    // lower the register in the middle of a block
    dir_rows.push_back(row_cfg(8'd1));
    dir_rows.push_back(row_item(1'b1, tsbm_pkg::TS_SYNC, 13'h1FFE, 1'b0, 1'b1, 16'h1234,
                                32'hFFFF_FFFF, 1'b0, 1'b0));
    // sequence wraps to zero on the next-sequence field
    dir_rows.push_back(row_item(1'b0, 8'h00, 13'h0000, 1'b1, 1'b1, 16'hFFFF,
                                32'h1234_5678, 1'b0, 1'b0));
    // missing first flag keeps the old start sequence
    dir_rows.push_back(row_item(1'b1, tsbm_pkg::TS_SYNC, 13'h0001, 1'b0, 1'b0, 16'h0005,
                                32'h8000_0000, 1'b1, 1'b1));
    dir_rows.push_back(row_item(1'b1, tsbm_pkg::TS_SYNC, 13'h1000, 1'b0, 1'b1, 16'h0006,
                                32'h8000_0000, 1'b0, 1'b0));
    // register zero
    dir_rows.push_back(row_cfg(8'd0));
    dir_rows.push_back(row_item(1'b1, 8'hFF, tsbm_pkg::NULL_PID, 1'b1, 1'b1, 16'h8000,
                                32'h0000_0001, 1'b0, 1'b0));
    dir_rows.push_back(row_cfg(8'd255));
    dir_rows.push_back(row_item(1'b1, tsbm_pkg::TS_SYNC, tsbm_pkg::NULL_PID, 1'b1, 1'b1,
                                16'h7FFF, 32'h5A5A_5A5A, 1'b1, 1'b1));
    dir_rows.push_back(row_item(1'b1, 8'h00, tsbm_pkg::NULL_PID, 1'b1, 1'b1, 16'h7FFF,
                                32'h5A5A_5A5A, 1'b1, 1'b0));
    dir_rows.push_back(row_cfg(8'd2));
    dir_rows.push_back(row_item(1'b1, tsbm_pkg::TS_SYNC, 13'h0000, 1'b1, 1'b1, 16'hABCD,
                                32'hA5A5_A5A5, 1'b0, 1'b0));
    dir_rows.push_back(row_item(1'b0, tsbm_pkg::TS_SYNC, 13'h0ABC, 1'b1, 1'b0, 16'h0000,
                                32'h0000_0000, 1'b1, 1'b0));
    dir_rows.push_back(row_item(1'b1, tsbm_pkg::TS_SYNC, 13'h0ABC, 1'b0, 1'b1, 16'h0000,
                                32'h0000_0000, 1'b1, 1'b1));

    // Hold reset, then release it once
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_rtp_per_marker(dir_rows[i].cfg_val);
      end else begin
        send_hdr(dir_rows[i].hdr, dir_rows[i].typed, dir_rows[i].typed_fwd);
      end
    end

    // Random packets, slow sender and slower receiver
    write_rtp_per_marker(8'($urandom_range(2, 8)));
    run_random(320);

    // Swap the stall rates
    send_idle_pct = 84;
    recv_idle_pct = 29;
    write_rtp_per_marker(8'd1);
    run_random(250);

    // Full rate: largest block size, then one packet per block
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_rtp_per_marker(8'd255);
    run_random(300);
    write_rtp_per_marker(8'd1);
    run_random(160);

    drain_results();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
